// File: rtl/mi3_pkg.sv
package mi3_pkg;

	// Fixed-point format of the matrix and inverse elements.
	localparam int FRAC_BITS = 16;
	localparam int EW = 32;

	localparam int LANES = 9;
	localparam int ROWS = 3;

	// Cofactor magnitude, determinant and divider widths.
	localparam int G_W = 2 * EW;
	localparam int DET_W = 3 * EW + 1;
	localparam int D_W = 3 * EW;
	localparam int N_W = G_W + 2 * FRAC_BITS;
	localparam int CMP_W = (N_W > D_W + EW) ? N_W : D_W + EW;
	localparam int PP_W = 2 * EW + 2;

	localparam int FIFO_AW = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	typedef struct packed {
		logic signed [EW-1:0] a00;
		logic signed [EW-1:0] a01;
		logic signed [EW-1:0] a02;
		logic signed [EW-1:0] a10;
		logic signed [EW-1:0] a11;
		logic signed [EW-1:0] a12;
		logic signed [EW-1:0] a20;
		logic signed [EW-1:0] a21;
		logic signed [EW-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [EW-1:0] b00;
		logic signed [EW-1:0] b01;
		logic signed [EW-1:0] b02;
		logic signed [EW-1:0] b10;
		logic signed [EW-1:0] b11;
		logic signed [EW-1:0] b12;
		logic signed [EW-1:0] b20;
		logic signed [EW-1:0] b21;
		logic signed [EW-1:0] b22;
		logic                 singular;
	} inv_t;

	// One classified matrix, handed from the front end to the divider.
	typedef struct packed {
		logic                       singular;
		logic [D_W-1:0]             dmag;
		logic [LANES-1:0]           neg;
		logic [LANES-1:0][G_W-1:0]  gmag;
	} work_t;

	// State of the nine division lanes in one divider stage.
	typedef struct packed {
		logic                       singular;
		logic [D_W-1:0]             dmag;
		logic [LANES-1:0]           neg;
		logic [LANES-1:0]           ovf;
		logic [LANES-1:0][N_W-1:0]  rem;
		logic [LANES-1:0][EW-1:0]   quo;
	} div_t;

endpackage

// File: rtl/mi3_mat_if.sv
interface mi3_mat_if;
	logic           valid;
	logic           ready;
	mi3_pkg::mat_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/mi3_inv_if.sv
interface mi3_inv_if;
	logic           valid;
	logic           ready;
	mi3_pkg::inv_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/mi3_front.sv
module mi3_front (
	input  logic            clk,
	input  logic            arst_n,
	mi3_mat_if.sink         mat_ch,
	output logic            push_valid,
	output mi3_pkg::work_t  push_data,
	input  logic            push_ready
);

	localparam int P_IDX [mi3_pkg::LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int Q_IDX [mi3_pkg::LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int R_IDX [mi3_pkg::LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
	localparam int S_IDX [mi3_pkg::LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int DET_LANE [mi3_pkg::ROWS] = '{0, 3, 6};

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [mi3_pkg::EW-1:0]    e [mi3_pkg::LANES];
	logic signed [2*mi3_pkg::EW-1:0]  ps_s1 [mi3_pkg::LANES];
	logic signed [2*mi3_pkg::EW-1:0]  qr_s1 [mi3_pkg::LANES];
	logic signed [mi3_pkg::EW-1:0]    row_s1 [mi3_pkg::ROWS];
	logic signed [2*mi3_pkg::EW:0]    g_s2 [mi3_pkg::LANES];
	logic signed [mi3_pkg::EW-1:0]    row_s2 [mi3_pkg::ROWS];
	logic signed [mi3_pkg::PP_W-1:0]  pl_s3 [mi3_pkg::ROWS];
	logic signed [mi3_pkg::PP_W-1:0]  ph_s3 [mi3_pkg::ROWS];
	logic [mi3_pkg::G_W-1:0]          gmag_s3 [mi3_pkg::LANES];
	logic [mi3_pkg::LANES-1:0]        gneg_s3;
	logic signed [mi3_pkg::DET_W-1:0] prod_s4 [mi3_pkg::ROWS];
	logic [mi3_pkg::G_W-1:0]          gmag_s4 [mi3_pkg::LANES];
	logic [mi3_pkg::LANES-1:0]        gneg_s4;
	logic signed [mi3_pkg::DET_W-1:0] det_s5;
	logic [mi3_pkg::G_W-1:0]          gmag_s5 [mi3_pkg::LANES];
	logic [mi3_pkg::LANES-1:0]        gneg_s5;
	logic [mi3_pkg::DET_W-1:0]        det_abs;

	// The whole front advances unless its last stage is held by a full queue.
	assign en = !vld_s5 || push_ready;
	assign mat_ch.ready = en;

	assign e[0] = mat_ch.data.a00;
	assign e[1] = mat_ch.data.a01;
	assign e[2] = mat_ch.data.a02;
	assign e[3] = mat_ch.data.a10;
	assign e[4] = mat_ch.data.a11;
	assign e[5] = mat_ch.data.a12;
	assign e[6] = mat_ch.data.a20;
	assign e[7] = mat_ch.data.a21;
	assign e[8] = mat_ch.data.a22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= mat_ch.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < mi3_pkg::LANES; k++) begin
				ps_s1[k] <= e[P_IDX[k]] * e[S_IDX[k]];
				qr_s1[k] <= e[Q_IDX[k]] * e[R_IDX[k]];
				g_s2[k] <= {ps_s1[k][2*mi3_pkg::EW-1], ps_s1[k]}
					- {qr_s1[k][2*mi3_pkg::EW-1], qr_s1[k]};
				gneg_s3[k] <= g_s2[k][2*mi3_pkg::EW];
				gmag_s3[k] <= g_s2[k][2*mi3_pkg::EW] ? mi3_pkg::G_W'(-g_s2[k])
					: mi3_pkg::G_W'(g_s2[k]);
				gmag_s4[k] <= gmag_s3[k];
				gmag_s5[k] <= gmag_s4[k];
			end
			gneg_s4 <= gneg_s3;
			gneg_s5 <= gneg_s4;
			for (int j = 0; j < mi3_pkg::ROWS; j++) begin
				row_s1[j] <= e[j];
				row_s2[j] <= row_s1[j];
				// Cofactor times row element, split at the word boundary.
				pl_s3[j] <= $signed({1'b0, g_s2[DET_LANE[j]][mi3_pkg::EW-1:0]}) * row_s2[j];
				ph_s3[j] <= $signed(g_s2[DET_LANE[j]][2*mi3_pkg::EW:mi3_pkg::EW]) * row_s2[j];
				prod_s4[j] <= (mi3_pkg::DET_W'(ph_s3[j]) <<< mi3_pkg::EW)
					+ mi3_pkg::DET_W'(pl_s3[j]);
			end
			det_s5 <= prod_s4[0] + prod_s4[1] + prod_s4[2];
		end
	end

	always_comb begin
		det_abs = det_s5[mi3_pkg::DET_W-1] ? -det_s5 : det_s5;
		push_data.singular = (det_s5 == '0);
		push_data.dmag = det_abs[mi3_pkg::D_W-1:0];
		for (int k = 0; k < mi3_pkg::LANES; k++) begin
			push_data.neg[k] = gneg_s5[k] ^ det_s5[mi3_pkg::DET_W-1];
			push_data.gmag[k] = gmag_s5[k];
		end
	end

	assign push_valid = vld_s5;

endmodule

// File: rtl/mi3_fifo.sv
module mi3_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  mi3_pkg::work_t  push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output mi3_pkg::work_t  pop_data,
	input  logic            pop_ready
);

	mi3_pkg::work_t               mem_q [mi3_pkg::FIFO_DEPTH];
	logic [mi3_pkg::FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [mi3_pkg::FIFO_AW:0]    cnt_q;
	logic                         push, pop;

	assign push_ready = (cnt_q != (mi3_pkg::FIFO_AW+1)'(mi3_pkg::FIFO_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: rtl/mi3_back.sv
module mi3_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  mi3_pkg::work_t  pop_data,
	output logic            pop_ready,
	mi3_inv_if.source       inv_ch
);

	localparam logic [mi3_pkg::EW-1:0] MAX_POS = {1'b0, {(mi3_pkg::EW-1){1'b1}}};
	localparam logic [mi3_pkg::EW-1:0] MIN_NEG = {1'b1, {(mi3_pkg::EW-1){1'b0}}};

	logic                     en;
	logic                     dv_vld_s [0:mi3_pkg::EW];
	mi3_pkg::div_t            dv_s [0:mi3_pkg::EW];
	mi3_pkg::div_t            dv_first;
	logic [mi3_pkg::EW-1:0]   res [mi3_pkg::LANES];
	logic                     out_vld_q;
	mi3_pkg::inv_t            out_q;

	// One restoring step: tries the divisor shifted up by the quotient bit weight.
	function automatic mi3_pkg::div_t div_step(mi3_pkg::div_t cur, int unsigned b);
		mi3_pkg::div_t nx;
		logic [mi3_pkg::CMP_W-1:0] dsh;
		logic [mi3_pkg::CMP_W-1:0] rw;
		nx = cur;
		dsh = mi3_pkg::CMP_W'(cur.dmag) << b;
		for (int k = 0; k < mi3_pkg::LANES; k++) begin
			rw = mi3_pkg::CMP_W'(cur.rem[k]);
			if (rw >= dsh) begin
				nx.rem[k] = mi3_pkg::N_W'(rw - dsh);
				nx.quo[k] = cur.quo[k] | (mi3_pkg::EW'(1) << b);
			end
		end
		return nx;
	endfunction

	assign en = !out_vld_q || inv_ch.ready;
	assign pop_ready = en;

	always_comb begin
		dv_first.singular = pop_data.singular;
		dv_first.dmag = pop_data.dmag;
		dv_first.neg = pop_data.neg;
		for (int k = 0; k < mi3_pkg::LANES; k++) begin
			dv_first.rem[k] = {pop_data.gmag[k], {(2*mi3_pkg::FRAC_BITS){1'b0}}};
			dv_first.quo[k] = '0;
			// A quotient that needs more than a full word saturates outright.
			dv_first.ovf[k] = mi3_pkg::CMP_W'(dv_first.rem[k])
				>= (mi3_pkg::CMP_W'(pop_data.dmag) << mi3_pkg::EW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_s[0] <= 1'b0;
		else if (en)
			dv_vld_s[0] <= pop_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			dv_s[0] <= dv_first;
	end

	for (genvar i = 1; i <= mi3_pkg::EW; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[i] <= 1'b0;
			else if (en)
				dv_vld_s[i] <= dv_vld_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en)
				dv_s[i] <= div_step(dv_s[i-1], mi3_pkg::EW - i);
		end
	end

	always_comb begin
		for (int k = 0; k < mi3_pkg::LANES; k++) begin
			priority if (dv_s[mi3_pkg::EW].singular)
				res[k] = '0;
			else if (dv_s[mi3_pkg::EW].neg[k]) begin
				if (dv_s[mi3_pkg::EW].ovf[k] || dv_s[mi3_pkg::EW].quo[k] > MIN_NEG)
					res[k] = MIN_NEG;
				else
					res[k] = -dv_s[mi3_pkg::EW].quo[k];
			end else begin
				if (dv_s[mi3_pkg::EW].ovf[k] || dv_s[mi3_pkg::EW].quo[k][mi3_pkg::EW-1])
					res[k] = MAX_POS;
				else
					res[k] = dv_s[mi3_pkg::EW].quo[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= dv_vld_s[mi3_pkg::EW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.b00 <= res[0];
			out_q.b01 <= res[1];
			out_q.b02 <= res[2];
			out_q.b10 <= res[3];
			out_q.b11 <= res[4];
			out_q.b12 <= res[5];
			out_q.b20 <= res[6];
			out_q.b21 <= res[7];
			out_q.b22 <= res[8];
			out_q.singular <= dv_s[mi3_pkg::EW].singular;
		end
	end

	assign inv_ch.valid = out_vld_q;
	assign inv_ch.data = out_q;

endmodule

// File: rtl/matrix_inverse_3x3_unit.sv
// Channel   Direction  Payload                               Transfer when
// mat_ch    in         a00..a22, signed Q16.16 row-major     valid && ready
// inv_ch    out        b00..b22 Q16.16 saturated, singular   valid && ready
//
// One matrix is accepted per cycle and one inverse leaves per cycle, sustained while the receiver is ready.
// A matrix passes the cofactor and determinant front end, the queue, the divider
// (an entry stage, then one quotient bit per stage) and the output register.
// Reset clears only valid flags, queue pointers and the queue count; no pass is needed.
// A stalled output holds the divider, and the four-entry queue lets the front
// end keep accepting until it fills.
module matrix_inverse_3x3_unit (
	input  logic        clk,
	input  logic        arst_n,
	mi3_mat_if.sink     mat_ch,
	mi3_inv_if.source   inv_ch
);

	// Front end to queue.
	logic            push_valid;
	logic            push_ready;
	mi3_pkg::work_t  push_data;

	// Queue to divider.
	logic            pop_valid;
	logic            pop_ready;
	mi3_pkg::work_t  pop_data;

	// The front end forms the nine cofactors and the determinant exactly, and
	// classifies the matrix as singular when the determinant is zero. It hands
	// over magnitudes and result signs so that the divider works unsigned.
	mi3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat_ch     (mat_ch),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// The queue decouples the two halves so that each can stall on its own.
	mi3_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	// The back end divides each scaled cofactor by the determinant in nine
	// pipelined restoring lanes, then saturates, applies the sign and zeroes singular results.
	mi3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready),
		.inv_ch     (inv_ch)
	);

endmodule

// File: rtl/mi3_checker.sv
module mi3_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic           out_valid,
	input  logic           out_ready,
	input  mi3_pkg::inv_t  out_data
);

	logic [6:0] outstanding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if ((in_valid && in_ready) && !(out_valid && out_ready))
			outstanding_q <= outstanding_q + 1'b1;
		else if (!(in_valid && in_ready) && (out_valid && out_ready))
			outstanding_q <= outstanding_q - 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |->
			out_data.b00 == '0 && out_data.b01 == '0 && out_data.b02 == '0 &&
			out_data.b10 == '0 && out_data.b11 == '0 && out_data.b12 == '0 &&
			out_data.b20 == '0 && out_data.b21 == '0 && out_data.b22 == '0)
		else $error("singular result with nonzero elements");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != '0)
		else $error("result shown with no matrix in flight");

endmodule

bind matrix_inverse_3x3_unit mi3_checker u_mi3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (mat_ch.valid),
	.in_ready  (mat_ch.ready),
	.out_valid (inv_ch.valid),
	.out_ready (inv_ch.ready),
	.out_data  (inv_ch.data)
);

// File: tb/mi3_inverse_checker.sv
module mi3_inverse_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mat_valid,
	input  logic            mat_ready,
	input  mi3_pkg::mat_t   mat_data,
	input  logic            inv_valid,
	input  logic            inv_ready,
	input  mi3_pkg::inv_t   inv_data,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	mi3_pkg::inv_t expected_inverses[$];

	function automatic logic signed [31:0] scale_cofactor(logic signed [127:0] cof,
			logic signed [127:0] det);
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] quo;
		logic neg;
		neg = cof[127] != det[127];
		num = (cof[127] ? -cof : cof) << (2 * mi3_pkg::FRAC_BITS);
		den = det[127] ? -det : det;
		quo = num / den;
		if (neg) begin
			if (quo > 128'h8000_0000)
				return 32'sh8000_0000;
			return -quo[31:0];
		end
		if (quo > 128'h7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		return quo[31:0];
	endfunction

	function automatic mi3_pkg::inv_t invert_matrix(mi3_pkg::mat_t m);
		logic signed [127:0] e[9];
		logic signed [127:0] g[9];
		logic signed [127:0] det;
		logic signed [31:0] b[9];
		mi3_pkg::inv_t r;
		e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
		e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
		e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
		g[0] = e[4] * e[8] - e[5] * e[7];
		g[1] = e[2] * e[7] - e[1] * e[8];
		g[2] = e[1] * e[5] - e[2] * e[4];
		g[3] = e[5] * e[6] - e[3] * e[8];
		g[4] = e[0] * e[8] - e[2] * e[6];
		g[5] = e[2] * e[3] - e[0] * e[5];
		g[6] = e[3] * e[7] - e[4] * e[6];
		g[7] = e[1] * e[6] - e[0] * e[7];
		g[8] = e[0] * e[4] - e[1] * e[3];
		det = g[0] * e[0] + g[3] * e[1] + g[6] * e[2];
		for (int k = 0; k < 9; k++)
			b[k] = (det == 0) ? 32'sd0 : scale_cofactor(g[k], det);
		r.b00 = b[0]; r.b01 = b[1]; r.b02 = b[2];
		r.b10 = b[3]; r.b11 = b[4]; r.b12 = b[5];
		r.b20 = b[6]; r.b21 = b[7]; r.b22 = b[8];
		r.singular = (det == 0);
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, actual %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk) begin
		mi3_pkg::inv_t want;
		if (arst_n) begin
			if (mat_valid && mat_ready)
				expected_inverses.push_back(invert_matrix(mat_data));
			if (inv_valid && inv_ready) begin
				if (expected_inverses.size() == 0) begin
					$error("inverse transfer with nothing expected");
					fail_count++;
				end else begin
					want = expected_inverses.pop_front();
					compare_field("b00", want.b00, inv_data.b00);
					compare_field("b01", want.b01, inv_data.b01);
					compare_field("b02", want.b02, inv_data.b02);
					compare_field("b10", want.b10, inv_data.b10);
					compare_field("b11", want.b11, inv_data.b11);
					compare_field("b12", want.b12, inv_data.b12);
					compare_field("b20", want.b20, inv_data.b20);
					compare_field("b21", want.b21, inv_data.b21);
					compare_field("b22", want.b22, inv_data.b22);
					compare_field("singular", want.singular, inv_data.singular);
				end
			end
		end
		pending <= expected_inverses.size();
	end
endmodule

// File: tb/matrix_inverse_3x3_unit_tb.sv
module matrix_inverse_3x3_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Pipeline depth from input transfer to output transfer.
	localparam int LATENCY = 40;
	// Cycles without any transfer before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int pending;
	int idle_cycles = 0;

	mi3_mat_if mat_ch();
	mi3_inv_if inv_ch();

	matrix_inverse_3x3_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.mat_ch(mat_ch),
		.inv_ch(inv_ch)
	);

	mi3_inverse_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.mat_valid(mat_ch.valid),
		.mat_ready(mat_ch.ready),
		.mat_data(mat_ch.data),
		.inv_valid(inv_ch.valid),
		.inv_ready(inv_ch.ready),
		.inv_data(inv_ch.data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #2 clk = ~clk;

	initial begin
		mat_ch.valid = 1'b0;
		mat_ch.data = '0;
		inv_ch.ready = 1'b0;
	end

	// An element drawn mostly from small Q16.16 values so that inverses stay in range,
	// with occasional full-width values and the extremes of the format.
	function automatic logic [31:0] random_element();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return $urandom_range(0, 3) - 1;
			4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
		endcase
	endfunction

	function automatic mi3_pkg::mat_t random_matrix();
		mi3_pkg::mat_t m;
		m.a00 = random_element(); m.a01 = random_element(); m.a02 = random_element();
		m.a10 = random_element(); m.a11 = random_element(); m.a12 = random_element();
		m.a20 = random_element(); m.a21 = random_element(); m.a22 = random_element();
		// Now and then copy the top row onto the bottom one so the determinant is
		// exactly zero.
		if ($urandom_range(0, 9) == 0) begin
			m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
		end
		return m;
	endfunction

	function automatic mi3_pkg::mat_t diag_matrix(logic [31:0] d0, logic [31:0] d1,
			logic [31:0] d2);
		mi3_pkg::mat_t m;
		m = '0;
		m.a00 = d0; m.a11 = d1; m.a22 = d2;
		return m;
	endfunction

	// Presents one matrix at the falling edge and holds it until its transfer.
	task automatic send_matrix(mi3_pkg::mat_t m);
		@(negedge clk);
		mat_ch.valid <= 1'b1;
		mat_ch.data <= m;
		@(posedge clk);
		while (!mat_ch.ready)
			@(posedge clk);
	endtask

	task automatic sender_gap();
		@(negedge clk);
		mat_ch.valid <= 1'b0;
		repeat ($urandom_range(1, 6))
			@(negedge clk);
	endtask

	// The receiver stalls in runs: sometimes always ready, sometimes choppy.
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(10, 80)) begin
				@(negedge clk);
				case (mode)
					0: inv_ch.ready <= 1'b1;
					1: inv_ch.ready <= ($urandom_range(0, 1) == 1);
					2: inv_ch.ready <= ($urandom_range(0, 7) == 0);
					default: inv_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Watchdog over cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((mat_ch.valid && mat_ch.ready) || (inv_ch.valid && inv_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		mi3_pkg::mat_t m;
		int burst;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed matrices: identity, scaled diagonals, saturation, singular cases.
		send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		send_matrix(diag_matrix(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000));
		send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
		send_matrix(diag_matrix(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
		send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_matrix(diag_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000));
		send_matrix('0);
		send_matrix({9{32'h8000_0000}});
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix({9{32'hFFFF_FFFF}});
		send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0000_0000));
		m = '0;
		m.a02 = 32'h0001_0000; m.a11 = 32'h0001_0000; m.a20 = 32'h0001_0000;
		send_matrix(m);
		m = '{a00: 32'h0002_0000, a01: 32'h0001_0000, a02: 32'h0,
			a10: 32'h0001_0000, a11: 32'h0003_0000, a12: 32'h0001_0000,
			a20: 32'h0, a21: 32'h0001_0000, a22: 32'h0004_0000};
		send_matrix(m);
		m.a00 = 32'h8000_0000; m.a22 = 32'h7FFF_FFFF;
		send_matrix(m);
		send_matrix(diag_matrix(32'h0000_0100, 32'hFFFF_FF00, 32'h0100_0000));

		// Hold off until the pipeline has drained completely.
		@(negedge clk);
		mat_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n += burst) begin
			burst = $urandom_range(1, 40);
			repeat (burst)
				send_matrix(random_matrix());
			if ($urandom_range(0, 2) != 0)
				sender_gap();
		end
		@(negedge clk);
		mat_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: files.f
rtl/mi3_pkg.sv
rtl/mi3_mat_if.sv
rtl/mi3_inv_if.sv
rtl/mi3_front.sv
rtl/mi3_fifo.sv
rtl/mi3_back.sv
rtl/matrix_inverse_3x3_unit.sv
rtl/mi3_checker.sv
tb/mi3_inverse_checker.sv
tb/matrix_inverse_3x3_unit_tb.sv
